FILE: rtl/rgb2hsv_pkg.sv
// shared types, constants and helpers for the rgb to hsv pixel converter
// no dependencies; imported by every module of the block
package rgb2hsv_pkg;

   localparam int PIX_W = 8;

   // divider: two quotient bits per stage, eight quotient bits in total
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = PIX_W / DIV_STEPS_PER_STAGE;

   // sort, scale, divider stages, output register
   localparam int PIPE_STAGES = 2 + DIV_STAGES + 1;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   localparam logic [PIX_W-1:0] BASE_RED   = 8'd0;
   localparam logic [PIX_W-1:0] BASE_GREEN = 8'd85;
   localparam logic [PIX_W-1:0] BASE_BLUE  = 8'd171;

   localparam logic [5:0] HUE_SCALE = 6'd43;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] hue;
      logic [PIX_W-1:0] saturation;
      logic [PIX_W-1:0] brightness;
   } rsp_type;

   // restoring divider lane: partial remainder, numerator bits still to
   // bring down, divisor and quotient collected so far
   typedef struct packed {
      logic [PIX_W-1:0] rem;
      logic [PIX_W-1:0] low;
      logic [PIX_W-1:0] den;
      logic [PIX_W-1:0] quot;
   } div_lane_type;

   // what travels beside the divider lanes
   typedef struct packed {
      logic [1:0]       sector;
      logic             neg;
      logic [PIX_W-1:0] brightness;
   } side_type;

   function automatic logic [PIX_W-1:0] hue_base(input logic [1:0] sector);
      logic [PIX_W-1:0] base;
      unique case (sector)
         SECTOR_RED:   base = BASE_RED;
         SECTOR_GREEN: base = BASE_GREEN;
         SECTOR_BLUE:  base = BASE_BLUE;
         default:      base = BASE_RED;
      endcase
      return base;
   endfunction

endpackage

FILE: rtl/rgb_to_hsv_8bit.sv
// top level of the 8-bit rgb to hsv pixel converter
// uses rgb2hsv_pkg, rgb2hsv_front and rgb2hsv_div_stage
//
//   channel   direction   handshake             payload
//   request   in          req_valid/req_stall   req_data  (red, green, blue)
//   response  out         rsp_valid/rsp_stall   rsp_data  (hue, saturation, brightness)
//
// seven register stages: sort, scale, four divider stages, output register
// one pixel per clock sustained while rsp_stall stays low
// the two restoring dividers, two quotient bits a stage, set the depth
// reset clears the stage valid bits only
// a stalled response lets bubbles close up; req_stall rises once every stage is full and rsp_stall is high
module rgb_to_hsv_8bit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rgb2hsv_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rgb2hsv_pkg::rsp_type  rsp_data
);
   import rgb2hsv_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] en;

   div_lane_type sat_lane [DIV_STAGES+1];
   div_lane_type hue_lane [DIV_STAGES+1];
   side_type     side     [DIV_STAGES+1];
   side_type     side_ff  [DIV_STAGES];

   rsp_type          rsp_in, rsp_ff;
   logic [PIX_W-1:0] sat_final;
   logic [PIX_W-1:0] base;
   logic [PIX_W-1:0] hue_off;

   // a stage takes new data when empty or when its contents move on
   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   rgb2hsv_front u_front (
      .clock    (clock),
      .en_sort  (en[0]),
      .en_scale (en[1]),
      .req_data (req_data),
      .sat_lane (sat_lane[0]),
      .hue_lane (hue_lane[0]),
      .side     (side[0])
   );

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      rgb2hsv_div_stage u_sat_div (
         .clock    (clock),
         .en       (en[k+2]),
         .lane_in  (sat_lane[k]),
         .lane_out (sat_lane[k+1])
      );

      rgb2hsv_div_stage u_hue_div (
         .clock    (clock),
         .en       (en[k+2]),
         .lane_in  (hue_lane[k]),
         .lane_out (hue_lane[k+1])
      );

      always_ff @(posedge clock) begin
         if (en[k+2]) begin
            side_ff[k] <= side[k];
         end
      end

      assign side[k+1] = side_ff[k];
   end

   // black pixel forces zero saturation; grey forces zero hue
   always_comb begin
      sat_final = (side[DIV_STAGES].brightness == '0) ? '0 : sat_lane[DIV_STAGES].quot;
      base      = hue_base(side[DIV_STAGES].sector);
      hue_off   = hue_lane[DIV_STAGES].quot;
      rsp_in.brightness = side[DIV_STAGES].brightness;
      rsp_in.saturation = sat_final;
      if (sat_final == '0) begin
         rsp_in.hue = '0;
      end else if (side[DIV_STAGES].neg) begin
         rsp_in.hue = base - hue_off;
      end else begin
         rsp_in.hue = base + hue_off;
      end
   end

   always_ff @(posedge clock) begin
      if (en[PIPE_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_STAGES-1];
   assign rsp_data  = rsp_ff;

   a_black_pixel : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.brightness == '0 |->
         rsp_data.saturation == '0 && rsp_data.hue == '0)
      else $error("black pixel with non-zero hue or saturation");

   a_grey_pixel : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturation == '0 |-> rsp_data.hue == '0)
      else $error("grey pixel with non-zero hue");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff == '1)
      else $error("request stalled while a stage is empty");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      en[0] && !req_valid |=> !valid_ff[0])
      else $error("first stage filled without a request");

endmodule

FILE: rtl/rgb2hsv_front.sv
// front end: channel sort, hue sector and difference, then numerator scaling
// two register stages; uses rgb2hsv_pkg
module rgb2hsv_front (
   input  logic                       clock,
   input  logic                       en_sort,
   input  logic                       en_scale,
   input  rgb2hsv_pkg::req_type       req_data,
   output rgb2hsv_pkg::div_lane_type  sat_lane,
   output rgb2hsv_pkg::div_lane_type  hue_lane,
   output rgb2hsv_pkg::side_type      side
);
   import rgb2hsv_pkg::*;

   logic [PIX_W-1:0] hi_in, lo_in, chroma_in, mag_in;
   logic [1:0]       sector_in;
   logic [PIX_W:0]   diff;

   logic [PIX_W-1:0] hi_ff, chroma_ff, mag_ff;
   logic [1:0]       sector_ff;
   logic             neg_ff;

   logic [2*PIX_W-1:0] sat_num, hue_num;
   div_lane_type       sat_lane_in, hue_lane_in, sat_lane_ff, hue_lane_ff;
   side_type           side_in, side_ff;

   // stage 1: max, min and the signed difference of the other two channels
   always_comb begin
      hi_in = (req_data.red > req_data.green) ? req_data.red : req_data.green;
      hi_in = (hi_in > req_data.blue) ? hi_in : req_data.blue;
      lo_in = (req_data.red < req_data.green) ? req_data.red : req_data.green;
      lo_in = (lo_in < req_data.blue) ? lo_in : req_data.blue;
      chroma_in = hi_in - lo_in;
      if (hi_in == req_data.red) begin
         sector_in = SECTOR_RED;
         diff = {1'b0, req_data.green} - {1'b0, req_data.blue};
      end else if (hi_in == req_data.green) begin
         sector_in = SECTOR_GREEN;
         diff = {1'b0, req_data.blue} - {1'b0, req_data.red};
      end else begin
         sector_in = SECTOR_BLUE;
         diff = {1'b0, req_data.red} - {1'b0, req_data.green};
      end
      // magnitude never exceeds 255, so the low byte holds it
      mag_in = diff[PIX_W] ? (~diff[PIX_W-1:0] + {{(PIX_W-1){1'b0}}, 1'b1})
                           : diff[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en_sort) begin
         hi_ff     <= hi_in;
         chroma_ff <= chroma_in;
         mag_ff    <= mag_in;
         sector_ff <= sector_in;
         neg_ff    <= diff[PIX_W];
      end
   end

   // stage 2: numerators 255*chroma and 43*|diff|
   always_comb begin
      sat_num = {chroma_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, chroma_ff};
      hue_num = {{PIX_W{1'b0}}, mag_ff} * {{(2*PIX_W-6){1'b0}}, HUE_SCALE};

      sat_lane_in.rem  = sat_num[2*PIX_W-1:PIX_W];
      sat_lane_in.low  = sat_num[PIX_W-1:0];
      sat_lane_in.den  = hi_ff;
      sat_lane_in.quot = '0;

      hue_lane_in.rem  = hue_num[2*PIX_W-1:PIX_W];
      hue_lane_in.low  = hue_num[PIX_W-1:0];
      hue_lane_in.den  = chroma_ff;
      hue_lane_in.quot = '0;

      side_in.sector     = sector_ff;
      side_in.neg        = neg_ff;
      side_in.brightness = hi_ff;
   end

   always_ff @(posedge clock) begin
      if (en_scale) begin
         sat_lane_ff <= sat_lane_in;
         hue_lane_ff <= hue_lane_in;
         side_ff     <= side_in;
      end
   end

   assign sat_lane = sat_lane_ff;
   assign hue_lane = hue_lane_ff;
   assign side     = side_ff;

endmodule

FILE: rtl/rgb2hsv_div_stage.sv
// one registered stage of the restoring divider, two quotient bits per stage
// uses rgb2hsv_pkg
module rgb2hsv_div_stage (
   input  logic                       clock,
   input  logic                       en,
   input  rgb2hsv_pkg::div_lane_type  lane_in,
   output rgb2hsv_pkg::div_lane_type  lane_out
);
   import rgb2hsv_pkg::*;

   div_lane_type lane_in_next;
   div_lane_type lane_ff;

   always_comb begin
      logic [PIX_W:0] trial;
      lane_in_next = lane_in;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         trial = {lane_in_next.rem, lane_in_next.low[PIX_W-1]};
         lane_in_next.low = {lane_in_next.low[PIX_W-2:0], 1'b0};
         if (trial >= {1'b0, lane_in_next.den}) begin
            trial = trial - {1'b0, lane_in_next.den};
            lane_in_next.rem  = trial[PIX_W-1:0];
            lane_in_next.quot = {lane_in_next.quot[PIX_W-2:0], 1'b1};
         end else begin
            lane_in_next.rem  = trial[PIX_W-1:0];
            lane_in_next.quot = {lane_in_next.quot[PIX_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_next;
      end
   end

   assign lane_out = lane_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb_to_hsv_8bit pixel converter
// depends on rgb2hsv_pkg for the request and response payload types
module tb;
   import rgb2hsv_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD = 300;
   localparam int HUE_STEP = 43;
   localparam int HUE_AT_RED = 0;
   localparam int HUE_AT_GREEN = 85;
   localparam int HUE_AT_BLUE = 171;

   typedef struct {
      req_type pixel;
      rsp_type hsv;
   } conversion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   conversion_type pending_hsv[$];
   int error_count = 0;
   int quiet_cycles = 0;
   int hold_off = 0;
   int stall_burst = 0;
   bit idle_on = 1'b1;

   rgb_to_hsv_8bit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // expected hue, saturation and brightness of one pixel
   function automatic rsp_type hsv_of_pixel(input req_type px);
      rsp_type res;
      logic [7:0] hi, lo, chroma;
      logic [15:0] sat;
      int base, diff, offs;
      hi = px.red;
      if (px.green > hi) hi = px.green;
      if (px.blue > hi) hi = px.blue;
      lo = px.red;
      if (px.green < lo) lo = px.green;
      if (px.blue < lo) lo = px.blue;
      chroma = hi - lo;
      sat = '0;
      res = '0;
      res.brightness = hi;
      if (hi != 0) sat = (16'd255 * chroma) / hi;
      res.saturation = sat[7:0];
      if (sat != 0) begin
         // ties go to red, then green
         if (hi == px.red) begin
            base = HUE_AT_RED;
            diff = int'(px.green) - int'(px.blue);
         end else if (hi == px.green) begin
            base = HUE_AT_GREEN;
            diff = int'(px.blue) - int'(px.red);
         end else begin
            base = HUE_AT_BLUE;
            diff = int'(px.red) - int'(px.green);
         end
         offs = (HUE_STEP * diff) / int'(chroma);
         res.hue = 8'(base + offs);
      end
      return res;
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      logic [7:0] a;
      logic [7:0] corners[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
      a = 8'($urandom);
      px = req_type'($urandom);
      case ($urandom_range(0, 6))
         0: px = '{red: a, green: a, blue: a};
         1: px.green = px.red;
         2: px.blue = px.green;
         3: px.red = px.blue;
         4: begin
            px.red = corners[$urandom_range(0, 3)];
            px.green = corners[$urandom_range(0, 3)];
            px.blue = corners[$urandom_range(0, 3)];
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want,
                              input req_type px);
      if (got !== want)
         report_mismatch($sformatf("rgb %0d,%0d,%0d %s got %0d want %0d",
                                   px.red, px.green, px.blue, field, got, want));
   endtask

   // offers one request, with an occasional gap first, and waits for acceptance
   task automatic send_pixel(input req_type px);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_stall);
      pending_hsv.push_back('{pixel: px, hsv: hsv_of_pixel(px)});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   // receiver side: long hold-off on request, otherwise random stall bursts while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_burst = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_response
      conversion_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hsv.size() == 0) begin
            report_mismatch($sformatf("response %0d,%0d,%0d with no request outstanding",
                                      rsp_data.hue, rsp_data.saturation, rsp_data.brightness));
         end else begin
            want = pending_hsv.pop_front();
            check_field("hue", rsp_data.hue, want.hsv.hue, want.pixel);
            check_field("saturation", rsp_data.saturation, want.hsv.saturation, want.pixel);
            check_field("brightness", rsp_data.brightness, want.hsv.brightness, want.pixel);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // black, white, greys, primaries, ties and hues that wrap below zero
   task automatic test_directed();
      req_type pixels[$] = '{
         '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
         '{8'd1, 8'd1, 8'd1}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
         '{8'd0, 8'd0, 8'd255}, '{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0},
         '{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
         '{8'd255, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd1}, '{8'd255, 8'd0, 8'd200},
         '{8'd200, 8'd100, 8'd150}, '{8'd255, 8'd254, 8'd255}, '{8'd254, 8'd255, 8'd0},
         '{8'd170, 8'd85, 8'd0}, '{8'd0, 8'd100, 8'd255}, '{8'd100, 8'd0, 8'd255},
         '{8'd2, 8'd1, 8'd0}, '{8'd255, 8'd1, 8'd0}
      };
      foreach (pixels[i]) send_pixel(pixels[i]);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // receiver holds off while requests keep coming, so the pipe fills and stalls
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_off = LONG_HOLD;
      repeat (40) send_pixel(random_pixel());
      wait_drained();
      idle_on = 1'b1;
   endtask

   // sender stops after each small batch until every response is back
   task automatic test_drain_pause();
      repeat (4) begin
         repeat (10) send_pixel(random_pixel());
         wait_drained();
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      repeat (150) send_pixel(random_pixel());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(500);
      test_backpressure();
      test_drain_pause();
      test_steady_stream();
      wait_drained();
      repeat (2 * PIPE_STAGES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
